// File: src/jtl_pkg.sv
package jtl_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] KIND_OBJSTART = 4'd0;
   localparam logic [3:0] KIND_OBJEND   = 4'd1;
   localparam logic [3:0] KIND_ARRSTART = 4'd2;
   localparam logic [3:0] KIND_ARREND   = 4'd3;
   localparam logic [3:0] KIND_STRING   = 4'd4;
   localparam logic [3:0] KIND_NUMBER   = 4'd5;
   localparam logic [3:0] KIND_BOOL     = 4'd6;
   localparam logic [3:0] KIND_COLON    = 4'd7;
   localparam logic [3:0] KIND_COMMA    = 4'd8;
   localparam logic [3:0] KIND_NULL     = 4'd9;
   localparam logic [3:0] KIND_END      = 4'd10;

   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LOW_T     = 8'h74;
   localparam logic [7:0] CH_LOW_F     = 8'h66;
   localparam logic [7:0] CH_LOW_N     = 8'h6E;
   localparam logic [7:0] CH_LOW_R     = 8'h72;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'd0,
      MODE_SLASH = 4'd1,
      MODE_LINE  = 4'd2,
      MODE_BLOCK = 4'd3,
      MODE_BSTAR = 4'd4,
      MODE_STR   = 4'd5,
      MODE_ESC   = 4'd6,
      MODE_NUM   = 4'd7,
      MODE_BOOL  = 4'd8,
      MODE_NULL  = 4'd9
   } mode_type;

   typedef struct packed {
      logic [3:0] kind;
      logic       has_char;
      logic [7:0] char_out;
      logic       token_done;
   } res_type;

   // one accepted character worth of results: one or two
   typedef struct packed {
      res_type first;
      res_type second;
      logic    has_second;
      logic    error_flag;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      mode_type mode;
      logic     set_err;
      logic     emit;
      res_type  res;
   } idle_type;

   function automatic res_type mk_res(logic [3:0] kind, logic has, logic [7:0] ch,
                                      logic done);
      res_type r;
      r.kind       = kind;
      r.has_char   = has;
      r.char_out   = has ? ch : 8'h00;
      r.token_done = done;
      return r;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   // classify a character seen between tokens
   function automatic idle_type lex_idle(logic [7:0] c);
      idle_type v;
      v.mode    = MODE_IDLE;
      v.set_err = 1'b0;
      v.emit    = 1'b0;
      v.res     = mk_res(KIND_END, 1'b0, 8'h00, 1'b0);
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
         v.mode = MODE_IDLE;
      end else if (c == CH_SLASH) begin
         v.mode = MODE_SLASH;
      end else if (c == CH_QUOTE) begin
         v.mode = MODE_STR;
      end else if (c == CH_LBRACE) begin
         v.emit = 1'b1;
         v.res  = mk_res(KIND_OBJSTART, 1'b1, c, 1'b1);
      end else if (c == CH_RBRACE) begin
         v.emit = 1'b1;
         v.res  = mk_res(KIND_OBJEND, 1'b1, c, 1'b1);
      end else if (c == CH_LBRACKET) begin
         v.emit = 1'b1;
         v.res  = mk_res(KIND_ARRSTART, 1'b1, c, 1'b1);
      end else if (c == CH_RBRACKET) begin
         v.emit = 1'b1;
         v.res  = mk_res(KIND_ARREND, 1'b1, c, 1'b1);
      end else if (c == CH_COLON) begin
         v.emit = 1'b1;
         v.res  = mk_res(KIND_COLON, 1'b1, c, 1'b1);
      end else if (c == CH_COMMA) begin
         v.emit = 1'b1;
         v.res  = mk_res(KIND_COMMA, 1'b1, c, 1'b1);
      end else if (is_digit(c) || c == CH_MINUS) begin
         v.mode = MODE_NUM;
         v.emit = 1'b1;
         v.res  = mk_res(KIND_NUMBER, 1'b1, c, 1'b0);
      end else if (c == CH_LOW_T || c == CH_LOW_F) begin
         v.mode = MODE_BOOL;
         v.emit = 1'b1;
         v.res  = mk_res(KIND_BOOL, 1'b1, c, 1'b0);
      end else if (c == CH_LOW_N) begin
         v.mode = MODE_NULL;
         v.emit = 1'b1;
         v.res  = mk_res(KIND_NULL, 1'b1, c, 1'b0);
      end else begin
         v.set_err = 1'b1;
      end
      return v;
   endfunction

endpackage

// File: src/jtl_front.sv
module jtl_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             cmd,
   input  logic [7:0]       char_in,
   output logic             push,
   output jtl_pkg::rec_type rec
);
   import jtl_pkg::*;

   mode_type mode_ff, mode_in;
   logic     err_ff, err_in;
   logic     first_v;
   idle_type iv;
   logic [7:0] esc_ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         err_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         err_ff  <= err_in;
      end
   end

   always_comb begin
      iv              = lex_idle(char_in);
      mode_in         = mode_ff;
      err_in          = err_ff;
      first_v         = 1'b0;
      rec.first       = mk_res(KIND_END, 1'b0, 8'h00, 1'b0);
      rec.second      = mk_res(KIND_END, 1'b0, 8'h00, 1'b0);
      rec.has_second  = 1'b0;
      rec.error_flag  = 1'b0;
      esc_ch          = char_in;
      if (char_in == CH_LOW_N) esc_ch = CH_LF;
      else if (char_in == CH_LOW_T) esc_ch = CH_TAB;
      else if (char_in == CH_LOW_R) esc_ch = CH_CR;

      if (cmd) begin
         // close any open token, then End
         unique case (mode_ff)
            MODE_STR, MODE_ESC: begin
               first_v   = 1'b1;
               rec.first = mk_res(KIND_STRING, 1'b0, 8'h00, 1'b1);
            end
            MODE_NUM: begin
               first_v   = 1'b1;
               rec.first = mk_res(KIND_NUMBER, 1'b0, 8'h00, 1'b1);
            end
            MODE_BOOL: begin
               first_v   = 1'b1;
               rec.first = mk_res(KIND_BOOL, 1'b0, 8'h00, 1'b1);
            end
            MODE_NULL: begin
               first_v   = 1'b1;
               rec.first = mk_res(KIND_NULL, 1'b0, 8'h00, 1'b1);
            end
            MODE_SLASH: err_in = 1'b1;
            default: ;
         endcase
         if (first_v) begin
            rec.second     = mk_res(KIND_END, 1'b0, 8'h00, 1'b1);
            rec.has_second = 1'b1;
         end else begin
            rec.first = mk_res(KIND_END, 1'b0, 8'h00, 1'b1);
         end
         first_v        = 1'b1;
         rec.error_flag = err_in;
         mode_in        = MODE_IDLE;
         err_in         = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_SLASH: begin
               if (char_in == CH_SLASH) begin
                  mode_in = MODE_LINE;
               end else if (char_in == CH_STAR) begin
                  mode_in = MODE_BLOCK;
               end else begin
                  err_in    = 1'b1;
                  mode_in   = iv.mode;
                  first_v   = iv.emit;
                  rec.first = iv.res;
               end
            end
            MODE_LINE: begin
               if (char_in == CH_LF) mode_in = MODE_IDLE;
            end
            MODE_BLOCK: begin
               if (char_in == CH_STAR) mode_in = MODE_BSTAR;
            end
            MODE_BSTAR: begin
               if (char_in == CH_SLASH) mode_in = MODE_IDLE;
               else if (char_in != CH_STAR) mode_in = MODE_BLOCK;
            end
            MODE_STR: begin
               first_v = 1'b1;
               if (char_in == CH_QUOTE) begin
                  rec.first = mk_res(KIND_STRING, 1'b0, 8'h00, 1'b1);
                  mode_in   = MODE_IDLE;
               end else if (char_in == CH_BACKSLASH) begin
                  first_v = 1'b0;
                  mode_in = MODE_ESC;
               end else begin
                  rec.first = mk_res(KIND_STRING, 1'b1, char_in, 1'b0);
               end
            end
            MODE_ESC: begin
               first_v   = 1'b1;
               rec.first = mk_res(KIND_STRING, 1'b1, esc_ch, 1'b0);
               mode_in   = MODE_STR;
            end
            MODE_NUM: begin
               first_v = 1'b1;
               if (is_digit(char_in) || char_in == CH_DOT) begin
                  rec.first = mk_res(KIND_NUMBER, 1'b1, char_in, 1'b0);
               end else begin
                  rec.first      = mk_res(KIND_NUMBER, 1'b0, 8'h00, 1'b1);
                  rec.second     = iv.res;
                  rec.has_second = iv.emit;
                  mode_in        = iv.mode;
                  err_in         = err_ff | iv.set_err;
               end
            end
            MODE_BOOL, MODE_NULL: begin
               first_v = 1'b1;
               if (is_alpha(char_in)) begin
                  rec.first = mk_res((mode_ff == MODE_BOOL) ? KIND_BOOL : KIND_NULL,
                                     1'b1, char_in, 1'b0);
               end else begin
                  rec.first      = mk_res((mode_ff == MODE_BOOL) ? KIND_BOOL : KIND_NULL,
                                          1'b0, 8'h00, 1'b1);
                  rec.second     = iv.res;
                  rec.has_second = iv.emit;
                  mode_in        = iv.mode;
                  err_in         = err_ff | iv.set_err;
               end
            end
            default: begin
               mode_in   = iv.mode;
               err_in    = err_ff | iv.set_err;
               first_v   = iv.emit;
               rec.first = iv.res;
            end
         endcase
         rec.error_flag = err_in;
      end
      push = accept && first_v;
   end

endmodule

// File: src/jtl_queue.sv
module jtl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jtl_pkg::rec_type   push_rec,
   input  logic               pop,
   output jtl_pkg::rec_type   head_rec,
   output jtl_pkg::qstat_type stat
);
   import jtl_pkg::*;

   rec_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_rec;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   assign head_rec   = slot_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   assert property (@(posedge clock) disable iff (reset) push |-> !stat.full)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> !stat.empty)
      else $error("queue read while empty");
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on write");

endmodule

// File: src/jtl_back.sv
module jtl_back (
   input  logic               clock,
   input  logic               reset,
   input  jtl_pkg::rec_type   head_rec,
   input  jtl_pkg::qstat_type stat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output jtl_pkg::res_type   rsp_res,
   output logic               rsp_err
);
   import jtl_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff;
   logic    rsp_err_ff;
   logic    sec_valid_ff, sec_valid_in;
   res_type sec_res_ff;
   logic    sec_err_ff;
   logic    load;

   always_comb begin
      load         = !rsp_valid_ff || !rsp_stall;
      pop          = load && !sec_valid_ff && !stat.empty;
      rsp_valid_in = rsp_valid_ff;
      sec_valid_in = sec_valid_ff;
      if (load) begin
         if (sec_valid_ff) begin
            rsp_valid_in = 1'b1;
            sec_valid_in = 1'b0;
         end else begin
            rsp_valid_in = !stat.empty;
            sec_valid_in = !stat.empty && head_rec.has_second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (sec_valid_ff) begin
            rsp_res_ff <= sec_res_ff;
            rsp_err_ff <= sec_err_ff;
         end else begin
            rsp_res_ff <= head_rec.first;
            rsp_err_ff <= head_rec.error_flag;
            sec_res_ff <= head_rec.second;
            sec_err_ff <= head_rec.error_flag;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_res_ff;
   assign rsp_err   = rsp_err_ff;

   // a held second result always sits behind a shown first one
   assert property (@(posedge clock) disable iff (reset) sec_valid_ff |-> rsp_valid_ff)
      else $error("second result pending without a shown result");
   assert property (@(posedge clock) disable iff (reset) (sec_valid_ff && load) |=> rsp_valid_ff)
      else $error("pending second result lost");

endmodule

// File: src/json_token_lexer.sv
// channel | direction | transfer when       | payload
// req     | in        | req_valid & !req_stall | req_cmd, req_char_in
// rsp     | out       | rsp_valid & !rsp_stall | rsp_kind, rsp_has_char, rsp_char_out,
//         |           |                        | rsp_token_done, rsp_error_flag
//
// One character is taken per cycle while req_stall is low; its results pass through the
// queue and then the output register. A character that closes a token and opens another
// gives two results, shown one after the other; a four-entry queue absorbs such bursts.
// req_stall rises only when the queue is full. Synchronous reset returns the lexer to idle,
// clears the sticky error and empties the queue.
module json_token_lexer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_kind,
   output logic       rsp_has_char,
   output logic [7:0] rsp_char_out,
   output logic       rsp_token_done,
   output logic       rsp_error_flag
);
   import jtl_pkg::*;

   logic      accept;
   logic      push;
   logic      pop;
   rec_type   push_rec;
   rec_type   head_rec;
   qstat_type stat;
   res_type   res;

   assign req_stall = stat.full;
   assign accept    = req_valid && !req_stall;

   jtl_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (req_cmd),
      .char_in (req_char_in),
      .push    (push),
      .rec     (push_rec)
   );

   jtl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .stat     (stat)
   );

   jtl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_rec  (head_rec),
      .stat      (stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (res),
      .rsp_err   (rsp_error_flag)
   );

   assign rsp_kind       = res.kind;
   assign rsp_has_char   = res.has_char;
   assign rsp_char_out   = res.char_out;
   assign rsp_token_done = res.token_done;

endmodule
